// ===== sv/rfhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfhc_pkg: shared types and constants of the receive frame header classifier
// Transaction payloads, header snapshot and status codes.
// ----------------------------------------------------------------------------
package rfhc_pkg;

	localparam int unsigned MAX_FRAME_BYTES_DEF = 2047;

	localparam logic [15:0] TAG_TYPE      = 16'h8100;
	localparam logic [15:0] MIN_ETHERTYPE = 16'h0600;
	localparam logic [23:0] LLC_SNAP      = 24'hAAAA03;

	localparam int unsigned NUM_ERR_FLAGS = 7;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_CRC         = 4'd1;
	localparam logic [3:0] ST_UNSPEC      = 4'd8;
	localparam logic [3:0] ST_UNSUPPORTED = 4'd9;
	localparam logic [3:0] ST_SHORT       = 4'd10;

	localparam logic [4:0] OFF_II        = 5'd14;
	localparam logic [4:0] OFF_II_TAG    = 5'd18;
	localparam logic [4:0] OFF_SNAP      = 5'd22;
	localparam logic [4:0] OFF_SNAP_TAG  = 5'd26;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       error_summary;
		logic [6:0] error_flags;
	} rx_item_t;

	typedef struct packed {
		logic [3:0]  frame_status;
		logic [15:0] protocol_type;
		logic        was_tagged;
		logic        was_snap;
		logic [4:0]  payload_offset;
		logic [10:0] payload_length;
	} result_t;

	// Header fields captured by the front end for one finished frame.
	typedef struct packed {
		logic        error_summary;
		logic [6:0]  error_flags;
		logic [15:0] outer_type;
		logic [15:0] inner_type;
		logic [23:0] llc_bytes;
		logic [15:0] snap_type;
	} hdr_t;

endpackage
`default_nettype wire

// ===== sv/rfhc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfhc_front: byte intake and header capture
// Counts frame bytes and captures type, LLC and SNAP fields; on the last
// byte it hands a header snapshot and the frame length to the queue.
// ----------------------------------------------------------------------------
module rfhc_front #(
	parameter int unsigned MAX_FRAME_BYTES = rfhc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rx_valid,
	output logic                  rx_stall,
	input  wire rfhc_pkg::rx_item_t rx_item,
	output logic                  job_push,
	output rfhc_pkg::hdr_t        job_hdr,
	output logic [LEN_W-1:0]      job_len,
	input  wire logic             job_full
);
	import rfhc_pkg::*;

	logic [LEN_W-1:0] cnt_q;
	logic [15:0]      outer_q, inner_q, snap_q;
	logic [23:0]      llc_q;
	logic [15:0]      outer_n, inner_n, snap_n;
	logic [23:0]      llc_n;
	logic             is_tagged;
	logic [LEN_W-1:0] llc0, snp0;
	logic             take;
	logic             cnt_sat;

	assign rx_stall = job_full;
	assign take     = rx_valid && !rx_stall;
	assign cnt_sat  = (cnt_q == LEN_W'(MAX_FRAME_BYTES));

	// LLC and SNAP fields sit four bytes later behind a tag.
	assign is_tagged = (outer_q == TAG_TYPE);
	assign llc0      = is_tagged ? LEN_W'(18) : LEN_W'(14);
	assign snp0      = is_tagged ? LEN_W'(24) : LEN_W'(20);

	always_comb begin
		outer_n = outer_q;
		inner_n = inner_q;
		llc_n   = llc_q;
		snap_n  = snap_q;
		if (cnt_q == LEN_W'(12)) outer_n[15:8] = rx_item.data_byte;
		if (cnt_q == LEN_W'(13)) outer_n[7:0]  = rx_item.data_byte;
		if (cnt_q == LEN_W'(16)) inner_n[15:8] = rx_item.data_byte;
		if (cnt_q == LEN_W'(17)) inner_n[7:0]  = rx_item.data_byte;
		if (cnt_q == llc0)               llc_n[23:16] = rx_item.data_byte;
		if (cnt_q == llc0 + LEN_W'(1))   llc_n[15:8]  = rx_item.data_byte;
		if (cnt_q == llc0 + LEN_W'(2))   llc_n[7:0]   = rx_item.data_byte;
		if (cnt_q == snp0)               snap_n[15:8] = rx_item.data_byte;
		if (cnt_q == snp0 + LEN_W'(1))   snap_n[7:0]  = rx_item.data_byte;
	end

	assign job_push              = take && rx_item.last_byte;
	assign job_hdr.error_summary = rx_item.error_summary;
	assign job_hdr.error_flags   = rx_item.error_flags;
	assign job_hdr.outer_type    = outer_n;
	assign job_hdr.inner_type    = inner_n;
	assign job_hdr.llc_bytes     = llc_n;
	assign job_hdr.snap_type     = snap_n;
	assign job_len               = cnt_sat ? cnt_q : cnt_q + LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			outer_q <= '0;
			inner_q <= '0;
			llc_q   <= '0;
			snap_q  <= '0;
		end else if (take) begin
			if (rx_item.last_byte) begin
				cnt_q   <= '0;
				outer_q <= '0;
				inner_q <= '0;
				llc_q   <= '0;
				snap_q  <= '0;
			end else begin
				if (!cnt_sat) cnt_q <= cnt_q + LEN_W'(1);
				outer_q <= outer_n;
				inner_q <= inner_n;
				llc_q   <= llc_n;
				snap_q  <= snap_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/rfhc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfhc_queue: two-entry queue between front and back end
// Holds finished frame snapshots so either side can stall on its own.
// ----------------------------------------------------------------------------
module rfhc_queue #(
	parameter int unsigned DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic                   full,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      rd_data,
	output logic                   not_empty
);
	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)      count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/rfhc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfhc_back: frame decode and result register
// Turns a header snapshot into status, protocol, offset and payload length.
// ----------------------------------------------------------------------------
module rfhc_back #(
	parameter int unsigned MAX_FRAME_BYTES = rfhc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_avail,
	input  wire rfhc_pkg::hdr_t     job_hdr,
	input  wire logic [LEN_W-1:0]   job_len,
	output logic                    job_pop,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output rfhc_pkg::result_t       res_item
);
	import rfhc_pkg::*;

	localparam int unsigned DW = (LEN_W > 11) ? LEN_W : 11;

	logic          res_valid_q;
	result_t       res_q;
	result_t       dec;
	logic          ready;
	logic [DW-1:0] len_x, diff;
	logic [3:0]    err_code;
	logic          is_tagged;
	logic [15:0]   typ;
	logic [4:0]    base;

	assign len_x = DW'(job_len);

	// Exactly one flag set maps to its code; anything else is unspecified.
	always_comb begin
		err_code = ST_UNSPEC;
		for (int b = 0; b < NUM_ERR_FLAGS; b++) begin
			if (job_hdr.error_flags == (7'd1 << b)) err_code = ST_CRC + 4'(b);
		end
	end

	assign is_tagged = (job_hdr.outer_type == TAG_TYPE);
	assign typ       = is_tagged ? job_hdr.inner_type : job_hdr.outer_type;
	assign base      = is_tagged ? OFF_II_TAG : OFF_II;

	always_comb begin
		dec = '0;
		dec.frame_status = ST_OK;
		if (job_hdr.error_summary) begin
			dec.frame_status = err_code;
		end else if (len_x < DW'(14)) begin
			dec.frame_status = ST_SHORT;
		end else if (is_tagged && len_x < DW'(18)) begin
			dec.frame_status = ST_SHORT;
		end else if (typ >= MIN_ETHERTYPE) begin
			dec.protocol_type  = typ;
			dec.payload_offset = base;
		end else if (len_x < DW'(base) + DW'(3)) begin
			dec.frame_status = ST_SHORT;
		end else if (job_hdr.llc_bytes != LLC_SNAP) begin
			dec.frame_status = ST_UNSUPPORTED;
		end else if (len_x < DW'(base) + DW'(8)) begin
			dec.frame_status = ST_SHORT;
		end else begin
			dec.was_snap       = 1'b1;
			dec.protocol_type  = job_hdr.snap_type;
			dec.payload_offset = is_tagged ? OFF_SNAP_TAG : OFF_SNAP;
		end
		dec.was_tagged = is_tagged && (dec.frame_status == ST_OK);
		if (dec.frame_status != ST_OK) begin
			dec.protocol_type  = '0;
			dec.was_snap       = 1'b0;
			dec.payload_offset = '0;
		end
		// Only used when the status is ok, where the length covers the offset.
		diff = len_x - DW'(dec.payload_offset);
		dec.payload_length = (diff > DW'(2047)) ? 11'h7FF : diff[10:0];
		if (dec.frame_status != ST_OK) dec.payload_length = '0;
	end

	assign ready   = !res_valid_q || !res_stall;
	assign job_pop = job_avail && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ready) begin
			res_valid_q <= job_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) res_q <= dec;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule
`default_nettype wire

// ===== sv/rx_frame_header_classifier.sv =====
// A frame's last byte queues its snapshot; the back end then registers its result.
// Throughput: one byte per cycle and one result per cycle, each while not stalled.
// The input stalls only while the queue between front and back end is full.
// Reset (arst_n low) clears the byte counter, captured header fields and queue.
// No clearing pass: the block takes bytes in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rx_frame_header_classifier: receive frame header classifier
// Parses Ethernet II, tagged and LLC/SNAP headers and reports one result per frame.
// ----------------------------------------------------------------------------
module rx_frame_header_classifier #(
	parameter int unsigned MAX_FRAME_BYTES = rfhc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rx_valid,
	output logic                    rx_stall,
	input  wire rfhc_pkg::rx_item_t rx_item,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output rfhc_pkg::result_t       res_item
);
	import rfhc_pkg::*;

	localparam int unsigned LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned DATA_W = $bits(hdr_t) + LEN_W;

	logic              job_push, job_full, job_pop, job_avail;
	hdr_t              push_hdr, pop_hdr;
	logic [LEN_W-1:0]  push_len, pop_len;
	logic [DATA_W-1:0] pop_data;

	rfhc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.LEN_W(LEN_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_item(rx_item),
		.job_push(job_push),
		.job_hdr(push_hdr),
		.job_len(push_len),
		.job_full(job_full)
	);

	rfhc_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.wr_data({push_hdr, push_len}),
		.full(job_full),
		.pop(job_pop),
		.rd_data(pop_data),
		.not_empty(job_avail)
	);

	assign pop_hdr = pop_data[DATA_W-1:LEN_W];
	assign pop_len = pop_data[LEN_W-1:0];

	rfhc_back #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.LEN_W(LEN_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_avail(job_avail),
		.job_hdr(pop_hdr),
		.job_len(pop_len),
		.job_pop(job_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

endmodule
`default_nettype wire

// ===== sv/rfhc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfhc_checker: port-level checks of the frame header classifier
// Watches the input and result channels for handshake and consistency slips.
// ----------------------------------------------------------------------------
module rfhc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               rx_valid,
	input wire logic               rx_stall,
	input wire rfhc_pkg::rx_item_t rx_item,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire rfhc_pkg::result_t  res_item
);
	import rfhc_pkg::*;

	// A stalled result transaction stays offered with the same payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.frame_status <= ST_SHORT)
		else $error("status code out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.frame_status != ST_OK |->
		res_item.protocol_type == '0 && !res_item.was_tagged && !res_item.was_snap &&
		res_item.payload_offset == '0 && res_item.payload_length == '0)
		else $error("fields set on a failed frame");

	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.frame_status == ST_OK |->
		(!res_item.was_snap && !res_item.was_tagged && res_item.payload_offset == OFF_II) ||
		(!res_item.was_snap && res_item.was_tagged && res_item.payload_offset == OFF_II_TAG) ||
		(res_item.was_snap && !res_item.was_tagged && res_item.payload_offset == OFF_SNAP) ||
		(res_item.was_snap && res_item.was_tagged && res_item.payload_offset == OFF_SNAP_TAG))
		else $error("payload offset does not match the decoded format");

	// The input can only stall once a finished frame has been taken in.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rx_stall) |-> $past(rx_valid && rx_item.last_byte))
		else $error("input stalled without a pending frame");

endmodule

bind rx_frame_header_classifier rfhc_checker u_rfhc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rx_valid(rx_valid),
	.rx_stall(rx_stall),
	.rx_item(rx_item),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_item(res_item)
);
`default_nettype wire

// ===== verif/rx_frame_header_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_frame_header_classifier_tb: self-checking bench for the frame classifier
// Streams Ethernet frames byte by byte (plain, tagged, LLC/SNAP, broken,
// short, errored and oversized ones), predicts each frame's result, and checks
// every result in order under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module rx_frame_header_classifier_tb;
	import rfhc_pkg::*;

	localparam int RANDOM_BYTES = 1850;

	typedef enum int {
		FR_II, FR_II_TAG, FR_SNAP, FR_SNAP_TAG, FR_BAD_LLC, FR_BAD_LLC_TAG, FR_NOISE
	} frame_kind_e;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     rx_valid = 1'b0;
	logic     rx_stall;
	rx_item_t rx_item = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	result_t  res_item;

	// Header snapshot of the frame in flight, as the block should hold it.
	int unsigned hdr_count = 0;
	logic [15:0] outer_word = '0;
	logic [15:0] inner_word = '0;
	logic [23:0] llc_word = '0;
	logic [15:0] snap_word = '0;

	result_t     expected_results[$];
	logic [7:0]  frame_buf[$];
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          mismatches = 0;
	int          frames_sent = 0;
	int          bytes_sent = 0;
	int          results_checked = 0;
	int          status_hits[16];

	rx_frame_header_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_item   (rx_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	function automatic logic [3:0] flag_status(input logic [6:0] flags);
		logic [3:0] st;
		st = ST_UNSPEC;
		for (int b = 0; b < NUM_ERR_FLAGS; b++)
			if (flags == (7'd1 << b))
				st = ST_CRC + 4'(b);
		return st;
	endfunction

	// Captures one accepted byte and, on the last byte of a frame, queues its result.
	task automatic classify_byte(input rx_item_t it);
		int unsigned pos, len, base, llc0, snp0, plen;
		logic is_tagged;
		logic [15:0] ethertype;
		result_t r;
		pos = hdr_count;
		llc0 = (outer_word == TAG_TYPE) ? int'(OFF_II_TAG) : int'(OFF_II);
		snp0 = llc0 + 6;
		case (pos)
			12: outer_word[15:8] = it.data_byte;
			13: outer_word[7:0] = it.data_byte;
			16: inner_word[15:8] = it.data_byte;
			17: inner_word[7:0] = it.data_byte;
			default: ;
		endcase
		if (pos >= llc0 && pos < llc0 + 3)
			llc_word[8 * (2 - (pos - llc0)) +: 8] = it.data_byte;
		if (pos == snp0)
			snap_word[15:8] = it.data_byte;
		if (pos == snp0 + 1)
			snap_word[7:0] = it.data_byte;

		if (!it.last_byte) begin
			if (hdr_count < MAX_FRAME_BYTES_DEF)
				hdr_count++;
		end else begin
			len = (pos + 1 > MAX_FRAME_BYTES_DEF) ? MAX_FRAME_BYTES_DEF : pos + 1;
			r = '0;
			is_tagged = (outer_word == TAG_TYPE);
			if (it.error_summary) begin
				r.frame_status = flag_status(it.error_flags);
			end else if (len < OFF_II) begin
				r.frame_status = ST_SHORT;
			end else begin
				ethertype = is_tagged ? inner_word : outer_word;
				base = is_tagged ? int'(OFF_II_TAG) : int'(OFF_II);
				if (is_tagged && len < OFF_II_TAG) begin
					r.frame_status = ST_SHORT;
				end else if (ethertype >= MIN_ETHERTYPE) begin
					r.protocol_type = ethertype;
					r.payload_offset = is_tagged ? OFF_II_TAG : OFF_II;
				end else if (len < base + 3) begin
					r.frame_status = ST_SHORT;
				end else if (llc_word != LLC_SNAP) begin
					r.frame_status = ST_UNSUPPORTED;
				end else if (len < base + 8) begin
					r.frame_status = ST_SHORT;
				end else begin
					r.was_snap = 1'b1;
					r.protocol_type = snap_word;
					r.payload_offset = is_tagged ? OFF_SNAP_TAG : OFF_SNAP;
				end
				if (r.frame_status == ST_OK) begin
					r.was_tagged = is_tagged;
					plen = len - r.payload_offset;
					r.payload_length = (plen > 2047) ? 11'd2047 : 11'(plen);
				end
			end
			expected_results.push_back(r);
			hdr_count = 0;
			outer_word = '0;
			inner_word = '0;
			llc_word = '0;
			snap_word = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("Result error (%s): expected st %0d type %h tag %0d snap %0d off %0d len %0d, got st %0d type %h tag %0d snap %0d off %0d len %0d",
				what, want.frame_status, want.protocol_type, want.was_tagged, want.was_snap,
				want.payload_offset, want.payload_length, got.frame_status, got.protocol_type,
				got.was_tagged, got.was_snap, got.payload_offset, got.payload_length);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("no frame pending", '0, got);
		end else begin
			want = expected_results.pop_front();
			results_checked++;
			status_hits[want.frame_status]++;
			if (got.frame_status !== want.frame_status ||
					got.protocol_type !== want.protocol_type ||
					got.was_tagged !== want.was_tagged ||
					got.was_snap !== want.was_snap ||
					got.payload_offset !== want.payload_offset ||
					got.payload_length !== want.payload_length)
				report_mismatch("field", want, got);
		end
	endtask

	// Both handshakes are judged on values settled before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall)
				classify_byte(rx_item);
			if (res_valid && !res_stall)
				check_result(res_item);
		end
	end

	task automatic send_rx_byte(input rx_item_t it);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= it;
		@(posedge clk);
		while (rx_stall !== 1'b0)
			@(posedge clk);
		bytes_sent++;
	endtask

	function automatic void put_byte(input int pos, input logic [7:0] v);
		if (pos < frame_buf.size())
			frame_buf[pos] = v;
	endfunction

	function automatic void put_word(input int pos, input logic [15:0] w);
		put_byte(pos, w[15:8]);
		put_byte(pos + 1, w[7:0]);
	endfunction

	// Builds a frame of the given format over random bytes and streams it.
	task automatic send_frame(input frame_kind_e kind, input int len, input logic [15:0] ptype,
			input logic es, input logic [6:0] flags);
		int base;
		logic is_tagged;
		logic [23:0] llc;
		rx_item_t it;
		frame_buf.delete();
		repeat (len)
			frame_buf.push_back(8'($urandom_range(255)));
		is_tagged = (kind == FR_II_TAG || kind == FR_SNAP_TAG || kind == FR_BAD_LLC_TAG);
		base = is_tagged ? int'(OFF_II_TAG) : int'(OFF_II);
		if (is_tagged)
			put_word(12, TAG_TYPE);
		case (kind)
			FR_II, FR_II_TAG: put_word(base - 2, ptype);
			FR_SNAP, FR_SNAP_TAG, FR_BAD_LLC, FR_BAD_LLC_TAG: begin
				llc = LLC_SNAP;
				if (kind == FR_BAD_LLC || kind == FR_BAD_LLC_TAG)
					llc[8 * $urandom_range(2) +: 8] ^= 8'($urandom_range(255, 1));
				put_word(base - 2, 16'($urandom_range(MIN_ETHERTYPE - 1)));
				put_byte(base, llc[23:16]);
				put_byte(base + 1, llc[15:8]);
				put_byte(base + 2, llc[7:0]);
				put_word(base + 6, ptype);
			end
			default: ;
		endcase
		for (int i = 0; i < frame_buf.size(); i++) begin
			it.data_byte = frame_buf[i];
			it.last_byte = (i == frame_buf.size() - 1);
			// Status bits are don't-care before the last byte, so they toggle freely.
			it.error_summary = it.last_byte ? es : 1'($urandom_range(1));
			it.error_flags = it.last_byte ? flags : 7'($urandom_range(127));
			send_rx_byte(it);
		end
		frames_sent++;
	endtask

	task automatic send_random_frame();
		int pick, hdr, len, r;
		frame_kind_e kind;
		logic [15:0] ptype;
		logic es;
		logic [6:0] flags;
		pick = $urandom_range(99);
		if (pick < 20) begin
			kind = FR_II; hdr = int'(OFF_II);
		end else if (pick < 38) begin
			kind = FR_II_TAG; hdr = int'(OFF_II_TAG);
		end else if (pick < 58) begin
			kind = FR_SNAP; hdr = int'(OFF_SNAP);
		end else if (pick < 75) begin
			kind = FR_SNAP_TAG; hdr = int'(OFF_SNAP_TAG);
		end else if (pick < 82) begin
			kind = FR_BAD_LLC; hdr = OFF_II + 3;
		end else if (pick < 88) begin
			kind = FR_BAD_LLC_TAG; hdr = OFF_II_TAG + 3;
		end else begin
			kind = FR_NOISE; hdr = 1;
		end

		r = $urandom_range(99);
		if (kind == FR_NOISE)
			len = $urandom_range(60, 1);
		else if (r < 10)
			len = $urandom_range(hdr - 1, 1);
		else if (r < 95)
			len = hdr + $urandom_range(24);
		else
			len = hdr + $urandom_range(120);

		ptype = 16'($urandom_range(16'hFFFF));
		if (kind == FR_II || kind == FR_II_TAG) begin
			ptype = 16'($urandom_range(16'hFFFF, MIN_ETHERTYPE));
			if (kind == FR_II && ptype == TAG_TYPE)
				ptype = MIN_ETHERTYPE;
		end

		es = ($urandom_range(99) < 12);
		flags = 7'($urandom_range(127));
		if (es && $urandom_range(99) < 70)
			flags = 7'd1 << $urandom_range(NUM_ERR_FLAGS - 1);
		send_frame(kind, len, ptype, es, flags);
	endtask

	task automatic test_error_status();
		for (int b = 0; b < NUM_ERR_FLAGS; b++)
			send_frame(FR_II, OFF_II + b, 16'h0800, 1'b1, 7'd1 << b);
		send_frame(FR_SNAP, 30, 16'h0800, 1'b1, 7'h00);
		send_frame(FR_II_TAG, 20, 16'h0800, 1'b1, 7'h7F);
		send_frame(FR_NOISE, 1, 16'h0000, 1'b1, 7'h20);
	endtask

	task automatic test_header_formats();
		send_frame(FR_II, int'(OFF_II), MIN_ETHERTYPE, 1'b0, 7'h7F);
		send_frame(FR_II, 60, 16'hFFFF, 1'b0, 7'h00);
		send_frame(FR_II_TAG, int'(OFF_II_TAG), 16'h0800, 1'b0, 7'h00);
		// A second tag word is just reported as the inner protocol.
		send_frame(FR_II_TAG, 40, TAG_TYPE, 1'b0, 7'h00);
		send_frame(FR_SNAP, int'(OFF_SNAP), 16'h0000, 1'b0, 7'h00);
		send_frame(FR_SNAP, 64, 16'hFFFF, 1'b0, 7'h00);
		send_frame(FR_SNAP_TAG, int'(OFF_SNAP_TAG), 16'h86DD, 1'b0, 7'h00);
		send_frame(FR_BAD_LLC, OFF_II + 3, 16'h0800, 1'b0, 7'h00);
		send_frame(FR_BAD_LLC_TAG, OFF_II_TAG + 3, 16'h0800, 1'b0, 7'h00);
		send_frame(FR_II, 30, MIN_ETHERTYPE - 16'd1, 1'b0, 7'h00);
	endtask

	task automatic test_short_frames();
		send_frame(FR_NOISE, 1, 16'h0000, 1'b0, 7'h00);
		send_frame(FR_II, OFF_II - 1, 16'h0800, 1'b0, 7'h00);
		send_frame(FR_II_TAG, int'(OFF_II), 16'h0800, 1'b0, 7'h00);
		send_frame(FR_II_TAG, OFF_II_TAG - 1, 16'h0800, 1'b0, 7'h00);
		send_frame(FR_SNAP, OFF_II + 2, 16'h0800, 1'b0, 7'h00);
		send_frame(FR_SNAP, OFF_SNAP - 1, 16'h0800, 1'b0, 7'h00);
		send_frame(FR_SNAP_TAG, OFF_II_TAG + 2, 16'h0800, 1'b0, 7'h00);
		send_frame(FR_SNAP_TAG, OFF_SNAP_TAG - 1, 16'h0800, 1'b0, 7'h00);
	endtask

	task automatic test_long_frame();
		send_frame(FR_SNAP_TAG, MAX_FRAME_BYTES_DEF + 3, 16'h0800, 1'b0, 7'h00);
	endtask

	task automatic test_random_traffic();
		int phase_start;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 57; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 57; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RANDOM_BYTES / 4)
				send_random_frame();
		end
	endtask

	initial begin
		int drain;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_error_status();
		test_header_formats();
		test_short_frames();
		test_long_frame();
		test_random_traffic();
		rx_valid <= 1'b0;

		drain = 0;
		while (expected_results.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d frame results never arrived", expected_results.size());
			mismatches += expected_results.size();
		end

		$display("Streamed %0d frames (%0d bytes) under four idle/stall mixes; %0d results checked.",
			frames_sent, bytes_sent, results_checked);
		$display("Status spread: ok %0d, unspecified error %0d, unsupported 802.3 %0d, short %0d.",
			status_hits[ST_OK], status_hits[ST_UNSPEC], status_hits[ST_UNSUPPORTED],
			status_hits[ST_SHORT]);
		if (mismatches == 0)
			$display("rx_frame_header_classifier: match");
		else
			$display("rx_frame_header_classifier: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d frame results pending", expected_results.size());
		$display("rx_frame_header_classifier: mismatch");
		$finish;
	end

endmodule
